// File: design/afc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types, codes and CRC helper for the authenticated frame checker.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam int          MIN_FRAME = 9;
    localparam int          HDR_BYTES = 7;

    localparam logic [1:0] REG_KEY_HIGH      = 2'd0;
    localparam logic [1:0] REG_KEY_LOW       = 2'd1;
    localparam logic [1:0] REG_JUMP_LIMIT    = 2'd2;
    localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_TAG      = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_REPLAY   = 3'd5;
    localparam logic [2:0] ST_JUMP     = 3'd6;

    typedef enum logic [2:0] {
        S_KEY,      // run the CRC over the key, one byte a cycle
        S_RECV,     // take frame bytes
        S_PRECHECK, // size, length and tag checks
        S_SEARCH,   // walk the tracker table
        S_OUT       // hold a result until taken
    } t_state;

    typedef struct packed {
        logic key_start;
        logic key_step;
        logic take_byte;
        logic precheck;
        logic search_start;
        logic search_step;
        logic load_out_byte;
        logic out_taken;
    } t_cmd;

    typedef struct packed {
        logic key_done;
        logic fwd;
        logic pre_final;
        logic search_done;
        logic verdict;
    } t_sts;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int j = 0; j < 8; j++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: design/authenticated_frame_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// authenticated_frame_checker_top
// Frame parser with keyed CRC-16 tag check and per-node replay tracking.
// ----------------------------------------------------------------------------
// Bytes enter one per item; a forwarded payload byte is accepted, then the held
// result must be taken before the next byte. At end of frame the size, length
// and tag checks run, then a table walk if they pass, and the verdict is held;
// after it is taken, the CRC restarts over the 16 key bytes, one byte a cycle,
// and no frame byte is taken until the key is done, also after reset. Config
// writes are held off during the key bytes and taken in every other state.
module authenticated_frame_checker_top #(
    parameter int NODE_SLOTS  = 10,
    parameter int FRAME_BYTES = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_end_of_frame,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_accepted,
    output logic [2:0]  o_status,
    output logic [7:0]  o_sender,
    output logic [31:0] o_sequence_res,
    output logic [15:0] o_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import afc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    afc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_eof       (i_end_of_frame),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    afc_datapath #(
        .NODE_SLOTS  (NODE_SLOTS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_byte         (i_frame_byte),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_sts          (w_sts),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_accepted     (o_accepted),
        .o_status       (o_status),
        .o_sender       (o_sender),
        .o_sequence_res (o_sequence_res),
        .o_length       (o_length)
    );

endmodule

// File: design/afc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_ctrl
// Sequencer: key CRC, byte reception, checks, table walk, result hold.
// ----------------------------------------------------------------------------
module afc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_eof,
    input  logic            i_out_ready,
    input  afc_pkg::t_sts   i_sts,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output logic            o_cfg_ready,
    output afc_pkg::t_cmd   o_cmd
);
    import afc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_KEY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cfg_ready = 1'b1;
        case (r_state)
            S_KEY: begin
                // hold off config writes while the key bytes are being hashed
                o_cfg_ready = 1'b0;
                o_cmd.key_step = 1'b1;
                if (i_sts.key_done) n_state = S_RECV;
            end
            S_RECV: begin
                o_in_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take_byte = 1'b1;
                    if (i_eof) begin
                        n_state = S_PRECHECK;
                    end else if (i_sts.fwd) begin
                        o_cmd.load_out_byte = 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_PRECHECK: begin
                o_cmd.precheck = 1'b1;
                if (i_sts.pre_final) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.search_start = 1'b1;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_sts.search_done) n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.out_taken = 1'b1;
                    if (i_sts.verdict) begin
                        // a verdict restarts the CRC from the key
                        o_cmd.key_start = 1'b1;
                        n_state = S_KEY;
                    end else begin
                        n_state = S_RECV;
                    end
                end
            end
            default: n_state = S_KEY;
        endcase
    end

endmodule

// File: design/afc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_datapath
// Header parse, byte CRC, config registers, tracker table and result register.
// ----------------------------------------------------------------------------
module afc_datapath #(
    parameter int NODE_SLOTS  = 10,
    parameter int FRAME_BYTES = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  afc_pkg::t_cmd   i_cmd,
    input  logic [7:0]      i_byte,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data,
    output afc_pkg::t_sts   o_sts,
    output logic            o_kind,
    output logic [7:0]      o_payload_byte,
    output logic            o_accepted,
    output logic [2:0]      o_status,
    output logic [7:0]      o_sender,
    output logic [31:0]     o_sequence_res,
    output logic [15:0]     o_length
);
    import afc_pkg::*;

    localparam int PW = $clog2(FRAME_BYTES + 1);
    localparam int SW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int CW = $clog2(NODE_SLOTS + 1);

    logic [63:0] r_key_high, r_key_low;
    logic [31:0] r_jump_limit;
    logic [15:0] r_payload_limit;

    logic [3:0]  r_key_idx;
    logic [15:0] r_crc;
    logic [PW-1:0] r_pos;
    logic [7:0]  r_node;
    logic [31:0] r_seq;
    logic [15:0] r_len;
    logic [15:0] r_tag;

    logic [7:0]  r_ids [NODE_SLOTS];
    logic [31:0] r_last [NODE_SLOTS];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;

    logic        r_kind, r_acc;
    logic [7:0]  r_pbyte;
    logic [2:0]  r_stat;
    logic [7:0]  r_snd;
    logic [31:0] r_sq;
    logic [15:0] r_ln;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high      <= 64'd1385812347856281261;
            r_key_low       <= 64'd13758142186802498576;
            r_jump_limit    <= 32'd5000;
            r_payload_limit <= 16'd230;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_HIGH:      r_key_high      <= i_cfg_data;
                REG_KEY_LOW:       r_key_low       <= i_cfg_data;
                REG_JUMP_LIMIT:    r_jump_limit    <= i_cfg_data[31:0];
                REG_PAYLOAD_LIMIT: r_payload_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // key byte selected by the key counter, first byte in the top bits
    logic [127:0] w_key;
    logic [7:0]   w_key_byte;
    assign w_key      = {r_key_high, r_key_low};
    assign w_key_byte = w_key[8'(127 - 8 * r_key_idx) -: 8];
    assign o_sts.key_done = (r_key_idx == 4'd15);

    logic [16:0] w_pay_end;
    logic        w_keep;
    assign w_pay_end = 17'(HDR_BYTES) + {1'b0, r_len};
    assign w_keep    = (r_pos < PW'(FRAME_BYTES));
    assign o_sts.fwd = w_keep && (r_pos >= PW'(HDR_BYTES))
                       && ({{(17 - PW){1'b0}}, r_pos} < w_pay_end);

    // precheck results
    logic w_short, w_badlen, w_tagbad;
    assign w_short  = (r_pos < PW'(MIN_FRAME));
    assign w_badlen = (r_len > r_payload_limit)
                      || (w_pay_end + 17'd2 > {{(17 - PW){1'b0}}, r_pos});
    assign w_tagbad = (r_crc != r_tag);
    assign o_sts.pre_final = w_short || w_badlen || w_tagbad;

    logic [SW-1:0] w_slot;
    logic          w_end, w_hit;
    logic [31:0]   w_diff;
    assign w_slot = r_idx[SW-1:0];
    assign w_end  = (r_idx >= r_count);
    assign w_hit  = !w_end && (r_ids[w_slot] == r_node);
    assign w_diff = r_seq - r_last[w_slot];
    assign o_sts.search_done = w_end || w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_idx <= '0;
            r_crc     <= CRC_INIT;
            r_pos     <= '0;
            r_node    <= '0;
            r_seq     <= '0;
            r_len     <= '0;
            r_tag     <= '0;
            r_count   <= '0;
            r_idx     <= '0;
        end else begin
            if (i_cmd.key_start) begin
                r_key_idx <= '0;
                r_crc     <= CRC_INIT;
            end else if (i_cmd.key_step && !o_sts.key_done) begin
                r_key_idx <= r_key_idx + 4'd1;
            end
            if (i_cmd.key_step) r_crc <= crc_byte(r_crc, w_key_byte);

            if (i_cmd.take_byte && w_keep) begin
                r_pos <= r_pos + PW'(1);
                if (r_pos == '0) begin
                    r_node <= i_byte;
                    r_crc  <= crc_byte(r_crc, i_byte);
                end else if (r_pos <= PW'(4)) begin
                    r_seq[8 * (r_pos[2:0] - 3'd1) +: 8] <= i_byte;
                    r_crc <= crc_byte(r_crc, i_byte);
                end else if (r_pos == PW'(5)) begin
                    r_len[7:0] <= i_byte;
                end else if (r_pos == PW'(6)) begin
                    r_len[15:8] <= i_byte;
                end else if (o_sts.fwd) begin
                    r_crc <= crc_byte(r_crc, i_byte);
                end else if ({{(17 - PW){1'b0}}, r_pos} == w_pay_end) begin
                    r_tag[7:0] <= i_byte;
                end else if ({{(17 - PW){1'b0}}, r_pos} == w_pay_end + 17'd1) begin
                    r_tag[15:8] <= i_byte;
                end
            end

            if (i_cmd.search_start) r_idx <= '0;
            if (i_cmd.search_step && !o_sts.search_done) r_idx <= r_idx + CW'(1);
            if (i_cmd.search_step && w_end && (r_count < CW'(NODE_SLOTS))) begin
                r_count <= r_count + CW'(1);
            end

            if (i_cmd.out_taken && r_kind) begin
                r_pos  <= '0;
                r_node <= '0;
                r_seq  <= '0;
                r_len  <= '0;
                r_tag  <= '0;
            end
        end
    end

    // table entries: payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.search_step) begin
            if (w_end && (r_count < CW'(NODE_SLOTS))) begin
                r_ids[w_slot]  <= r_node;
                r_last[w_slot] <= r_seq;
            end else if (w_hit && (r_seq > r_last[w_slot]) && (w_diff <= r_jump_limit)) begin
                r_last[w_slot] <= r_seq;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out_byte) begin
            r_kind  <= 1'b0;
            r_pbyte <= i_byte;
            r_acc   <= 1'b0;
            r_stat  <= ST_OK;
            r_snd   <= '0;
            r_sq    <= '0;
            r_ln    <= '0;
        end else if (i_cmd.precheck) begin
            r_kind  <= 1'b1;
            r_pbyte <= '0;
            r_acc   <= 1'b0;
            r_snd   <= w_short ? 8'd0 : r_node;
            r_sq    <= w_short ? 32'd0 : r_seq;
            r_ln    <= w_short ? 16'd0 : r_len;
            r_stat  <= w_short ? ST_SHORT : (w_badlen ? ST_BAD_LEN : ST_TAG);
        end else if (i_cmd.search_step && o_sts.search_done) begin
            if (w_end) begin
                r_acc  <= (r_count < CW'(NODE_SLOTS));
                r_stat <= (r_count < CW'(NODE_SLOTS)) ? ST_OK : ST_FULL;
            end else if (r_seq <= r_last[w_slot]) begin
                r_stat <= ST_REPLAY;
            end else if (w_diff > r_jump_limit) begin
                r_stat <= ST_JUMP;
            end else begin
                r_acc  <= 1'b1;
                r_stat <= ST_OK;
            end
        end
    end

    assign o_sts.verdict  = r_kind;

    assign o_kind         = r_kind;
    assign o_payload_byte = r_pbyte;
    assign o_accepted     = r_acc;
    assign o_status       = r_stat;
    assign o_sender       = r_snd;
    assign o_sequence_res = r_sq;
    assign o_length       = r_ln;

endmodule

// File: design/afc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_checker
// Port-level checks on the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module afc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_kind,
    input logic        o_accepted,
    input logic [2:0]  o_status
);
    import afc_pkg::*;

    ap_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input taken while result pending");

    ap_acc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_accepted == (o_kind && o_status == ST_OK)))
        else $error("accepted disagrees with status");

    ap_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> (o_status == ST_OK))
        else $error("payload item carries a status");

    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_kind) && $stable(o_status)))
        else $error("result dropped while stalled");

endmodule

bind authenticated_frame_checker_top afc_checker u_afc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_kind     (o_kind),
    .o_accepted (o_accepted),
    .o_status   (o_status)
);
